[sv/byte_ring_queue_with_peek_macros.svh]
// Assertion helpers for the ring queue datapath.
// Compiled out when SYNTHESIS is defined.
`ifndef BYTE_RING_QUEUE_WITH_PEEK_MACROS_SVH
`define BYTE_RING_QUEUE_WITH_PEEK_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BRQ_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ring queue check failed");

// Next-cycle implication.
`define BRQ_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ring queue sequencing check failed");

`else

`define BRQ_ASSERT_IMP(label, ck, rn, ante, cons)
`define BRQ_ASSERT_NXT(label, ck, rn, ante, cons)

`endif

`endif

[sv/brq_pkg.sv]
`timescale 1ns / 1ps

package brq_pkg;

    // Field widths
    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 9;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic capture;    // latch an accepted request
        logic exec;       // access the store, update pointers
        logic load;       // move the result into the output register
        logic cfg_write;  // take a new capacity and clear the queue
    } brq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_full;   // output register holds an untaken result
    } brq_status_t;

endpackage

[sv/brq_ctrl.sv]
`timescale 1ns / 1ps

module brq_ctrl
    import brq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        out_ready,
    input  brq_status_t status,
    output brq_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration takes priority over a request in the same cycle.
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;

    always_comb
    begin
        cmd.capture   = in_valid && in_ready;
        cmd.cfg_write = cfg_valid && cfg_ready;
        cmd.exec      = (state_reg == S_EXEC);
        cmd.load      = (state_reg == S_FIN) && (!status.out_full || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Hold until the output register is free.
                if (cmd.load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/brq_datapath.sv]
`timescale 1ns / 1ps
`include "byte_ring_queue_with_peek_macros.svh"

module brq_datapath
    import brq_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  brq_cmd_t          cmd,
    output brq_status_t       status,
    input  logic [CMD_W-1:0]  cmd_in,
    input  logic [BYTE_W-1:0] data_in,
    input  logic [CNT_W-1:0]  amount,
    input  logic [BYTE_W-1:0] offset,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [BYTE_W-1:0] data_out,
    output logic              ok,
    output logic [CNT_W-1:0]  count,
    output logic              empty_res,
    output logic              overwrote
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam logic [SW-1:0]    DEPTH_S    = SW'(DEPTH);
    localparam logic [CNT_W-1:0] RESET_SIZE = (DEPTH < 256) ? CNT_W'(DEPTH) : CNT_W'(256);

    // Latched request
    logic [CMD_W-1:0]  cmd_reg;
    logic [BYTE_W-1:0] din_reg;
    logic [CNT_W-1:0]  amount_reg;
    logic [BYTE_W-1:0] offset_reg;

    // Queue state
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] size_reg, size_next;

    // Store
    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Execute results
    logic ok_reg, ok_next;
    logic ovw_reg, ovw_next;
    logic rdf_reg, rdf_next;
    logic          wr_en;
    logic [PW-1:0] rd_addr;

    // Output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] data_out_reg;
    logic              ok_out_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              empty_reg;
    logic              ovw_out_reg;

    logic [SW-1:0] size_s;
    logic [SW-1:0] head_inc, tail_inc, head_disc, peek_sum;
    logic [PW-1:0] head_wrap, tail_wrap, disc_wrap, peek_wrap;
    logic [CNT_W-1:0] cfg_size;

    always_comb
    begin
        size_s    = SW'(size_reg);
        head_inc  = SW'(head_reg) + SW'(1);
        tail_inc  = SW'(tail_reg) + SW'(1);
        head_disc = SW'(head_reg) + SW'(amount_reg);
        peek_sum  = SW'(head_reg) + SW'(offset_reg);
        // Each sum stays below twice the ring size on every accepted path.
        head_wrap = (head_inc >= size_s) ? PW'(head_inc - size_s) : PW'(head_inc);
        tail_wrap = (tail_inc >= size_s) ? PW'(tail_inc - size_s) : PW'(tail_inc);
        disc_wrap = (head_disc >= size_s) ? PW'(head_disc - size_s) : PW'(head_disc);
        peek_wrap = (peek_sum >= size_s) ? PW'(peek_sum - size_s) : PW'(peek_sum);
    end

    // Clamp the capacity into one to DEPTH.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_size = CNT_W'(1);
        end
        else if (SW'(cfg_data) > DEPTH_S)
        begin
            cfg_size = CNT_W'(DEPTH);
        end
        else
        begin
            cfg_size = cfg_data;
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        size_next = size_reg;
        ok_next   = 1'b0;
        ovw_next  = 1'b0;
        rdf_next  = 1'b0;
        wr_en     = 1'b0;
        rd_addr   = head_reg;

        case (cmd_reg)
            CMD_APPEND:
            begin
                wr_en     = 1'b1;
                tail_next = tail_wrap;
                ok_next   = 1'b1;
                if (fill_reg < size_reg)
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                else
                begin
                    head_next = head_wrap;
                    ovw_next  = 1'b1;
                end
            end
            CMD_GET:
            begin
                if (fill_reg != '0)
                begin
                    head_next = head_wrap;
                    fill_next = fill_reg - CNT_W'(1);
                    ok_next   = 1'b1;
                    rdf_next  = 1'b1;
                end
            end
            CMD_DISCARD:
            begin
                if (amount_reg <= fill_reg)
                begin
                    head_next = disc_wrap;
                    fill_next = fill_reg - amount_reg;
                    ok_next   = 1'b1;
                end
            end
            CMD_PEEK:
            begin
                rd_addr = peek_wrap;
                if (CNT_W'(offset_reg) < fill_reg)
                begin
                    ok_next  = 1'b1;
                    rdf_next = 1'b1;
                end
            end
            CMD_STATUS:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase

        if (!cmd.exec)
        begin
            head_next = head_reg;
            tail_next = tail_reg;
            fill_next = fill_reg;
            wr_en     = 1'b0;
        end

        if (cmd.cfg_write)
        begin
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
            size_next = cfg_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            size_reg      <= RESET_SIZE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
            size_reg <= size_next;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg    <= cmd_in;
            din_reg    <= data_in;
            amount_reg <= amount;
            offset_reg <= offset;
        end
        if (cmd.exec)
        begin
            ok_reg  <= ok_next;
            ovw_reg <= ovw_next;
            rdf_reg <= rdf_next;
        end
        if (cmd.load)
        begin
            data_out_reg <= rdf_reg ? rdata_reg : '0;
            ok_out_reg   <= ok_reg;
            count_reg    <= fill_reg;
            empty_reg    <= (fill_reg == '0);
            ovw_out_reg  <= ovw_reg;
        end
    end

    // Ring store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= din_reg;
        end
        if (cmd.exec)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign status.out_full = out_valid_reg;
    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign ok        = ok_out_reg;
    assign count     = count_reg;
    assign empty_res = empty_reg;
    assign overwrote = ovw_out_reg;

    `BRQ_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= size_reg)
    `BRQ_ASSERT_IMP(a_head_bound, clk, rst_n, 1'b1, SW'(head_reg) < SW'(size_reg))
    `BRQ_ASSERT_IMP(a_tail_bound, clk, rst_n, 1'b1, SW'(tail_reg) < SW'(size_reg))
    `BRQ_ASSERT_NXT(a_load_valid, clk, rst_n, cmd.load, out_valid_reg)

endmodule

[sv/byte_ring_queue_with_peek.sv]
`timescale 1ns / 1ps

// Byte ring queue with peek. Each request carries a command: append a byte at
// the tail, get the oldest byte, discard a number of bytes from the head, peek
// at a byte a given distance from the head, or read status; every request
// yields exactly one result with the byte read (zero unless a get or peek
// succeeds), an ok flag, the byte count after the command, an empty flag and
// an overwrite flag. Appending to a full ring replaces the oldest byte and the
// head moves on with the tail. A get on an empty ring, a discard of more bytes
// than held, a peek at or past the count and an unknown command are refused
// with ok low and leave the queue as it was. Writing the capacity register
// (zero acts as one, values above DEPTH act as DEPTH) empties the queue; write
// it only while no request is in flight. A request is latched when accepted,
// executes in the execute state (a registered read and a write of the byte
// store on separate ports, together with the pointer update) and moves its
// result into the output register in the finish state, which waits while the
// output register holds an untaken result; the input takes the next request
// only after that load. The output register frees the input side, so the
// next request is taken while a result still waits; a result that is not
// taken holds the block once the next one is ready to load. The store needs
// no clearing after reset.
module byte_ring_queue_with_peek
    import brq_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic              clk,
    input  logic              rst_n,

    // Request channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [BYTE_W-1:0] data_in,
    input  logic [CNT_W-1:0]  amount,
    input  logic [BYTE_W-1:0] offset,

    // Result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] data_out,
    output logic              ok,
    output logic [CNT_W-1:0]  count,
    output logic              empty_res,
    output logic              overwrote,

    // Capacity register write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data
);

    brq_cmd_t    ctl;
    brq_status_t sts;

    // Sequence each request: latch, execute, load result.
    brq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .out_ready (out_ready),
        .status    (sts),
        .cmd       (ctl)
    );

    // Hold the pointers, the byte store and the output register.
    brq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl),
        .status    (sts),
        .cmd_in    (cmd),
        .data_in   (data_in),
        .amount    (amount),
        .offset    (offset),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .data_out  (data_out),
        .ok        (ok),
        .count     (count),
        .empty_res (empty_res),
        .overwrote (overwrote)
    );

endmodule

[dv/byte_ring_queue_with_peek_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the byte ring queue. A short table of requests hits
// the edges first: empty-ring refusals, unknown commands, zero and oversize
// discards, capacity zero and above the ring depth, overwrite on a full ring.
// Random segments follow, each behind a capacity write, with mostly
// well-formed traffic that is aware of the fill level. A behavioral copy of
// the queue predicts every result that the table does not give by hand, and
// the result side compares each one in order.
module byte_ring_queue_with_peek_tb;
    import brq_pkg::*;

    localparam int RING_DEPTH   = 256;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int SEG_COUNT    = 7;

    // Command codes the block does not define; each one must be refused.
    localparam logic [CMD_W-1:0] CMD_UNDEF_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNDEF_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNDEF_HI  = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_in;
        logic [CNT_W-1:0]  amount;
        logic [BYTE_W-1:0] offset;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              ok;
        logic [CNT_W-1:0]  count;
        logic              empty_res;
        logic              overwrote;
    } res_t;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_in;
        logic [CNT_W-1:0]  amount;
        logic [BYTE_W-1:0] offset;
        logic [CNT_W-1:0]  cap;
        logic              typed;   // want holds a result read off by hand
        res_t              want;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    // Directed requests. Rows with typed set carry their expected result;
    // the others go to the predictor.
    localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
        // fresh after reset, capacity 256, ring empty
        '{ROW_REQ, CMD_STATUS,    8'h00, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b1, 9'd0, 1'b1, 1'b0}},
        '{ROW_REQ, CMD_GET,       8'h00, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b0, 9'd0, 1'b1, 1'b0}},
        '{ROW_REQ, CMD_PEEK,      8'h00, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b0, 9'd0, 1'b1, 1'b0}},
        '{ROW_REQ, CMD_DISCARD,   8'h00, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b1, 9'd0, 1'b1, 1'b0}},
        '{ROW_REQ, CMD_DISCARD,   8'h00, 9'd511, 8'd0,   9'd0, 1'b1, '{8'h00, 1'b0, 9'd0, 1'b1, 1'b0}},
        '{ROW_REQ, CMD_UNDEF_HI,  8'hFF, 9'd511, 8'd255, 9'd0, 1'b1, '{8'h00, 1'b0, 9'd0, 1'b1, 1'b0}},
        '{ROW_REQ, CMD_UNDEF_LO,  8'h00, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b0, 9'd0, 1'b1, 1'b0}},
        // two bytes in, read back by peek and get
        '{ROW_REQ, CMD_APPEND,    8'hFF, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b1, 9'd1, 1'b0, 1'b0}},
        '{ROW_REQ, CMD_APPEND,    8'h00, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b1, 9'd2, 1'b0, 1'b0}},
        '{ROW_REQ, CMD_PEEK,      8'h00, 9'd0,   8'd1,   9'd0, 1'b0, '0},
        '{ROW_REQ, CMD_PEEK,      8'h00, 9'd0,   8'd255, 9'd0, 1'b1, '{8'h00, 1'b0, 9'd2, 1'b0, 1'b0}},
        '{ROW_REQ, CMD_GET,       8'h00, 9'd0,   8'd0,   9'd0, 1'b0, '0},
        // capacity zero behaves as a one-slot ring
        '{ROW_CFG, CMD_STATUS,    8'h00, 9'd0,   8'd0,   9'd0, 1'b0, '0},
        '{ROW_REQ, CMD_APPEND,    8'hA5, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b1, 9'd1, 1'b0, 1'b0}},
        '{ROW_REQ, CMD_APPEND,    8'h5A, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b1, 9'd1, 1'b0, 1'b1}},
        '{ROW_REQ, CMD_PEEK,      8'h00, 9'd0,   8'd0,   9'd0, 1'b0, '0},
        // capacity above the depth behaves as the full ring
        '{ROW_CFG, CMD_STATUS,    8'h00, 9'd0,   8'd0,   9'd511, 1'b0, '0},
        '{ROW_REQ, CMD_APPEND,    8'h3C, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b1, 9'd1, 1'b0, 1'b0}},
        '{ROW_REQ, CMD_DISCARD,   8'h00, 9'd1,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b1, 9'd0, 1'b1, 1'b0}},
        // two-slot ring: overwrite, then a discard of more than is held
        '{ROW_CFG, CMD_STATUS,    8'h00, 9'd0,   8'd0,   9'd2, 1'b0, '0},
        '{ROW_REQ, CMD_APPEND,    8'h11, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b1, 9'd1, 1'b0, 1'b0}},
        '{ROW_REQ, CMD_APPEND,    8'h22, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b1, 9'd2, 1'b0, 1'b0}},
        '{ROW_REQ, CMD_APPEND,    8'h33, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b1, 9'd2, 1'b0, 1'b1}},
        '{ROW_REQ, CMD_GET,       8'h00, 9'd0,   8'd0,   9'd0, 1'b0, '0},
        '{ROW_REQ, CMD_DISCARD,   8'h00, 9'd2,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b0, 9'd1, 1'b0, 1'b0}},
        '{ROW_REQ, CMD_UNDEF_MID, 8'h00, 9'd0,   8'd0,   9'd0, 1'b1, '{8'h00, 1'b0, 9'd1, 1'b0, 1'b0}}
    };

    // DUT ports
    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_in;
    logic [CNT_W-1:0]  amount;
    logic [BYTE_W-1:0] offset;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] data_out;
    logic              ok;
    logic [CNT_W-1:0]  count;
    logic              empty_res;
    logic              overwrote;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;

    // Shadow copy of the queue
    logic [BYTE_W-1:0] shadow_mem [RING_DEPTH];
    int                shadow_head;
    int                shadow_tail;
    int                shadow_fill;
    logic [CNT_W-1:0]  shadow_cap;

    // Results still owed by the block, oldest first
    res_t              pending_results [$];

    // Traffic shaping shared by both sides
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    bit                hold_req      = 1'b0;
    int                hold_left     = 0;

    // Bookkeeping
    int                cycle_cnt   = 0;
    int                n_err       = 0;
    int                n_sent      = 0;
    int                n_checked   = 0;
    int                n_cfg       = 0;
    int                n_overwrite = 0;
    int                n_refused   = 0;
    int                n_holds     = 0;

    byte_ring_queue_with_peek #(
        .DEPTH (RING_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .data_in   (data_in),
        .amount    (amount),
        .offset    (offset),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out),
        .ok        (ok),
        .count     (count),
        .empty_res (empty_res),
        .overwrote (overwrote),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Run watchdog: abort well past the slowest legal run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("byte_ring_queue_with_peek_tb NOT OK");
            $finish;
        end
    end

    // Apply one request to the shadow queue and return the result it owes.
    function automatic res_t ring_apply(input req_t r);
        res_t o;
        int   span;
        o    = '0;
        // Clamp the capacity: zero acts as one, above the depth as the depth.
        span = (shadow_cap == 0) ? 1 :
               (int'(shadow_cap) > RING_DEPTH) ? RING_DEPTH : int'(shadow_cap);
        case (r.cmd)
            CMD_APPEND:
            begin
                shadow_mem[shadow_tail] = r.data_in;
                shadow_tail = (shadow_tail + 1) % span;
                if (shadow_fill < span)
                    shadow_fill++;
                else
                begin
                    // Full ring: drop the oldest byte, move the head on.
                    shadow_head = (shadow_head + 1) % span;
                    o.overwrote = 1'b1;
                end
                o.ok = 1'b1;
            end
            CMD_GET:
            begin
                if (shadow_fill != 0)
                begin
                    o.data_out  = shadow_mem[shadow_head];
                    shadow_head = (shadow_head + 1) % span;
                    shadow_fill--;
                    o.ok = 1'b1;
                end
            end
            CMD_DISCARD:
            begin
                if (int'(r.amount) <= shadow_fill)
                begin
                    shadow_head = (shadow_head + int'(r.amount)) % span;
                    shadow_fill -= int'(r.amount);
                    o.ok = 1'b1;
                end
            end
            CMD_PEEK:
            begin
                if (int'(r.offset) < shadow_fill)
                begin
                    o.data_out = shadow_mem[(shadow_head + int'(r.offset)) % span];
                    o.ok = 1'b1;
                end
            end
            CMD_STATUS:
                o.ok = 1'b1;
            default:
                ;
        endcase
        o.count     = shadow_fill[CNT_W-1:0];
        o.empty_res = (shadow_fill == 0);
        if (o.overwrote)
            n_overwrite++;
        if (!o.ok)
            n_refused++;
        return o;
    endfunction

    // Draw a random request shaped by the current fill level, so that most
    // peeks and discards land inside the bytes held.
    function automatic req_t pick_request(input int append_pct);
        req_t r;
        int   p;
        int   lim;
        r.cmd     = CMD_STATUS;
        r.data_in = BYTE_W'($urandom_range(0, 255));
        r.amount  = CNT_W'($urandom_range(0, 511));
        r.offset  = BYTE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < append_pct)
            r.cmd = CMD_APPEND;
        else
        begin
            p = $urandom_range(0, 99);
            if (p < 25)
                r.cmd = CMD_GET;
            else if (p < 55)
            begin
                r.cmd = CMD_PEEK;
                if (shadow_fill > 0 && $urandom_range(0, 99) < 85)
                    r.offset = BYTE_W'($urandom_range(0, shadow_fill - 1));
            end
            else if (p < 80)
            begin
                r.cmd = CMD_DISCARD;
                if ($urandom_range(0, 99) < 80)
                begin
                    // Favor short discards so the ring does not drain at once.
                    lim = (shadow_fill > 4 && $urandom_range(0, 1)) ? 4 : shadow_fill;
                    r.amount = CNT_W'($urandom_range(0, lim));
                end
            end
            else if (p < 92)
                r.cmd = CMD_STATUS;
            else
                r.cmd = CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
        end
        return r;
    endfunction

    // Offer one request, holding it until accepted, then log what it owes.
    // Call at a rising edge; leaves in_valid high for the caller to reuse.
    task automatic send_request(input req_t r, input logic typed, input res_t typed_res);
        res_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= r.cmd;
        data_in  <= r.data_in;
        amount   <= r.amount;
        offset   <= r.offset;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = ring_apply(r);
        pending_results.push_back(typed ? typed_res : predicted);
        n_sent++;
    endtask

    // Write the capacity once every owed result is back; the write empties
    // the queue, so reset the shadow pointers with it.
    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        shadow_cap  = cap;
        shadow_head = 0;
        shadow_tail = 0;
        shadow_fill = 0;
        n_cfg++;
    endtask

    // Result side: check every accepted result, then pick the next ready.
    always @(posedge clk)
    begin : result_side
        res_t got;
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{data_out, ok, count, empty_res, overwrote};
            if (pending_results.size() == 0)
            begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("unexpected result: data %h ok %0d count %0d empty %0d ovw %0d",
                             got.data_out, got.ok, got.count, got.empty_res,
                             got.overwrote);
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.data_out !== want.data_out || got.ok !== want.ok ||
                    got.count !== want.count || got.empty_res !== want.empty_res ||
                    got.overwrote !== want.overwrote)
                begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                    begin
                        $display("result %0d: want data %h ok %0d count %0d empty %0d ovw %0d",
                                 n_checked, want.data_out, want.ok, want.count,
                                 want.empty_res, want.overwrote);
                        $display("    got data %h ok %0d count %0d empty %0d ovw %0d",
                                 got.data_out, got.ok, got.count, got.empty_res,
                                 got.overwrote);
                    end
                end
            end
        end
        // Hold off for a long stretch on request, else stall at random.
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            n_holds++;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Request side: reset, directed table, then random segments.
    initial
    begin : request_side
        int   seg_cap [SEG_COUNT];
        int   seg_len;
        int   append_pct;
        req_t r;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = CMD_STATUS;
        data_in   = '0;
        amount    = '0;
        offset    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        shadow_cap  = 9'd256;
        shadow_head = 0;
        shadow_tail = 0;
        shadow_fill = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles 38 in 100, receiver 65 in 100.
        send_idle_pct = 38;
        recv_idle_pct = 65;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TBL[i].kind == ROW_CFG)
                write_capacity(DIR_TBL[i].cap);
            else
                send_request('{DIR_TBL[i].cmd, DIR_TBL[i].data_in, DIR_TBL[i].amount,
                               DIR_TBL[i].offset}, DIR_TBL[i].typed, DIR_TBL[i].want);
        end

        // Capacity per segment: full ring first, then tiny rings, one above
        // the depth, two random sizes and one just under the depth.
        seg_cap[0] = 256;
        seg_cap[1] = 1;
        seg_cap[2] = 3;
        seg_cap[3] = 257;
        seg_cap[4] = $urandom_range(4, 40);
        seg_cap[5] = $urandom_range(1, 256);
        seg_cap[6] = 255;

        for (int s = 0; s < SEG_COUNT; s++)
        begin
            // Swap the idle rates after the first three segments, then drop
            // idling for the last two.
            if (s == 3)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 38;
            end
            else if (s == 5)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(seg_cap[s][CNT_W-1:0]);
            // The full-ring segment leans on appends long enough to wrap.
            seg_len    = (s == 0) ? 380 : 110;
            append_pct = (s == 0) ? 65 : 40;
            for (int k = 0; k < seg_len; k++)
            begin
                // Stall the result side while requests keep coming, so the
                // block fills and pushes back on its input.
                if ((s == 0 && k == 100) || (s == 5 && k == 40))
                    hold_req = 1'b1;
                r = pick_request(append_pct);
                send_request(r, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
            n_err++;

        $display("sent %0d requests (%0d table rows), checked %0d results",
                 n_sent, DIR_ROWS, n_checked);
        $display("%0d capacity writes, %0d overwrites, %0d refusals, %0d long stalls, %0d errors",
                 n_cfg, n_overwrite, n_refused, n_holds, n_err);
        if (n_err == 0)
            $display("byte_ring_queue_with_peek_tb OK");
        else
            $display("byte_ring_queue_with_peek_tb NOT OK");
        $finish;
    end

endmodule
